[rtl/keqs_pkg.sv]
package keqs_pkg;

   localparam int NUM_QUEUES  = 64;
   localparam int QUEUE_DEPTH = 16;

   localparam int SLOT_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int EV_ADDR_W  = SLOT_W + PTR_W;
   localparam int EV_ENTRIES = NUM_QUEUES * (2 ** PTR_W);

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAN = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_NOQ   = 2'd3;

   typedef struct packed {
      logic [7:0]  kind;
      logic [31:0] control;
      logic [31:0] window;
      logic [63:0] callback;
   } keqs_event_type;

   typedef struct packed {
      logic [PTR_W-1:0] rd;
      logic [PTR_W-1:0] wr;
   } keqs_ptr_type;

   typedef struct packed {
      logic capture;
      logic resolve;
      logic execute;
      logic load;
   } keqs_cmd_type;

   typedef struct packed {
      logic out_free;
   } keqs_stat_type;

   function automatic logic [PTR_W-1:0] ptr_incr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

[rtl/keqs_ctrl.sv]
module keqs_ctrl
   import keqs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  keqs_stat_type stat,
   output keqs_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_RESOLVE = 4'b0010,
      S_EXEC    = 4'b0100,
      S_LOAD    = 4'b1000
   } keqs_state_type;

   keqs_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/keqs_dp.sv]
module keqs_dp
   import keqs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  keqs_cmd_type  cmd,
   output keqs_stat_type stat,
   input  logic [1:0]    req_operation,
   input  logic [31:0]   req_owner_id,
   input  logic [7:0]    req_event_kind,
   input  logic [31:0]   req_control_ident,
   input  logic [31:0]   req_window_ident,
   input  logic [63:0]   req_callback_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output logic [7:0]    rsp_got_kind,
   output logic [31:0]   rsp_got_control,
   output logic [31:0]   rsp_got_window,
   output logic [63:0]   rsp_got_callback
);

   logic [31:0]           owner_ff [NUM_QUEUES];
   logic [31:0]           owner_in [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] hit_ff, free_ff;
   logic [1:0]            op_ff;
   logic [31:0]           id_ff;
   keqs_event_type        ev_ff;

   logic                  hit_any, free_any;
   logic [SLOT_W-1:0]     hit_idx, free_idx, slot_in;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  slot_ok_ff, claim_ff;

   keqs_ptr_type          ptr_mem [NUM_QUEUES];
   keqs_ptr_type          ptr_q, ptr_new;
   logic [PTR_W-1:0]      cur_rd, cur_wr, rd_nxt, wr_nxt;
   logic                  full, empty, push_ok, pop_ok;
   logic                  is_rw;
   logic [1:0]            status_in;
   logic [EV_ADDR_W-1:0]  ev_addr;

   keqs_event_type        ev_mem [EV_ENTRIES];
   keqs_event_type        ev_q;
   logic [1:0]            status_ff;
   logic                  pop_ok_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   keqs_event_type        rsp_event_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff          <= req_operation;
         id_ff          <= req_owner_id;
         ev_ff.kind     <= req_event_kind;
         ev_ff.control  <= req_control_ident;
         ev_ff.window   <= req_window_ident;
         ev_ff.callback <= req_callback_word;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            hit_ff[i]  <= (owner_ff[i] == req_owner_id);
            free_ff[i] <= (owner_ff[i] == 32'd0);
         end
      end
   end

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (free_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      hit_any  = |hit_ff;
      free_any = |free_ff;
      slot_in  = hit_any ? hit_idx : free_idx;
      is_rw    = (op_ff == OP_PUSH) || (op_ff == OP_POP);
   end

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         owner_in[i] = owner_ff[i];
      end
      if (cmd.resolve && (id_ff != 32'd0)) begin
         if (is_rw && !hit_any && free_any) begin
            owner_in[free_idx] = id_ff;
         end else if ((op_ff == OP_CLEAN) && hit_any) begin
            owner_in[hit_idx] = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            owner_ff[i] <= 32'd0;
         end
      end else begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            owner_ff[i] <= owner_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         slot_ff    <= slot_in;
         slot_ok_ff <= (id_ff != 32'd0) && (hit_any || free_any);
         claim_ff   <= !hit_any;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         ptr_q <= ptr_mem[slot_in];
      end
      if (cmd.execute && slot_ok_ff && is_rw) begin
         ptr_mem[slot_ff] <= ptr_new;
      end
   end

   always_comb begin
      cur_rd  = claim_ff ? '0 : ptr_q.rd;
      cur_wr  = claim_ff ? '0 : ptr_q.wr;
      rd_nxt  = ptr_incr(cur_rd);
      wr_nxt  = ptr_incr(cur_wr);
      full    = (wr_nxt == cur_rd);
      empty   = (cur_rd == cur_wr);
      push_ok = (op_ff == OP_PUSH) && slot_ok_ff && !full;
      pop_ok  = (op_ff == OP_POP) && slot_ok_ff && !empty;
      ptr_new.rd = pop_ok ? rd_nxt : cur_rd;
      ptr_new.wr = push_ok ? wr_nxt : cur_wr;
      ev_addr = {slot_ff, (op_ff == OP_POP) ? cur_rd : cur_wr};
      case (op_ff)
         OP_PUSH: begin
            if (!slot_ok_ff) begin
               status_in = ST_NOQ;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_DONE;
            end
         end
         OP_POP: begin
            if (!slot_ok_ff) begin
               status_in = ST_NOQ;
            end else if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_DONE;
            end
         end
         OP_CLEAN: begin
            status_in = (id_ff == 32'd0) ? ST_NOQ : ST_DONE;
         end
         default: begin
            status_in = ST_NOQ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && push_ok) begin
         ev_mem[ev_addr] <= ev_ff;
      end
      if (cmd.execute && pop_ok) begin
         ev_q <= ev_mem[ev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_event_ff  <= pop_ok_ff ? ev_q : '0;
      end
   end

   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_got_kind     = rsp_event_ff.kind;
   assign rsp_got_control  = rsp_event_ff.control;
   assign rsp_got_window   = rsp_event_ff.window;
   assign rsp_got_callback = rsp_event_ff.callback;

endmodule

[rtl/keyed_event_queue_set.sv]
// Set of per-process event ring queues. A new request (push, pop or cleanup
// of the queue owned by req_owner_id) is taken only once the previous one
// has loaded its result. The transfer cycle compares the id against every
// slot owner in parallel, the next cycle picks the owned or lowest free slot
// and reads its ring pointers from the single-port pointer memory, the
// execute state writes or reads the single-port event memory and updates
// the pointers, and the load state loads the output register once it is
// free. The next request is taken as soon as the controller is back in
// idle, while an earlier result may still wait in the output register. A
// ring holds one event fewer than its depth; stored events are not cleared
// by reset and are never returned unless written since the slot was claimed.
module keyed_event_queue_set
   import keqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_owner_id,
   input  logic [7:0]  req_event_kind,
   input  logic [31:0] req_control_ident,
   input  logic [31:0] req_window_ident,
   input  logic [63:0] req_callback_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_got_kind,
   output logic [31:0] rsp_got_control,
   output logic [31:0] rsp_got_window,
   output logic [63:0] rsp_got_callback
);

   keqs_cmd_type  cmd;
   keqs_stat_type stat;

   keqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   keqs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_owner_id      (req_owner_id),
      .req_event_kind    (req_event_kind),
      .req_control_ident (req_control_ident),
      .req_window_ident  (req_window_ident),
      .req_callback_word (req_callback_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_got_kind      (rsp_got_kind),
      .rsp_got_control   (rsp_got_control),
      .rsp_got_window    (rsp_got_window),
      .rsp_got_callback  (rsp_got_callback)
   );

endmodule

[rtl/keqs_checker.sv]
module keqs_checker
   import keqs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_got_kind,
   input logic [31:0] rsp_got_control,
   input logic [31:0] rsp_got_window,
   input logic [63:0] rsp_got_callback
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result withdrawn before its transfer.");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("Request taken while an earlier one is still in work.");

   a_no_data_unless_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |->
         (rsp_got_kind == 8'd0) && (rsp_got_control == 32'd0) &&
         (rsp_got_window == 32'd0) && (rsp_got_callback == 64'd0))
      else $error("Event fields set on a result that is not a successful pop.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result offered right after reset.");

endmodule

bind keyed_event_queue_set keqs_checker u_keqs_checker (.*);

[tb/keyed_event_queue_set_tb.sv]
`timescale 1ns / 100ps

module keyed_event_queue_set_tb
   import keqs_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int POOL_SIZE = 10;

   typedef struct packed {
      logic [1:0]     op;
      logic [31:0]    id;
      keqs_event_type ev;
   } request_type;

   typedef struct packed {
      logic [1:0]     status;
      keqs_event_type ev;
   } outcome_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_owner_id = '0;
   logic [7:0]  req_event_kind = '0;
   logic [31:0] req_control_ident = '0;
   logic [31:0] req_window_ident = '0;
   logic [63:0] req_callback_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_got_kind;
   logic [31:0] rsp_got_control;
   logic [31:0] rsp_got_window;
   logic [63:0] rsp_got_callback;

   request_type pending_requests[$];
   outcome_type awaited_outcomes[$];
   request_type request_on_bus;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   logic     hold_rsp = 1'b0;
   int       mismatches = 0;

   bit [31:0]        ring_owner[NUM_QUEUES];
   bit [PTR_W-1:0]   ring_rd[NUM_QUEUES];
   bit [PTR_W-1:0]   ring_wr[NUM_QUEUES];
   keqs_event_type   stored_events[NUM_QUEUES*QUEUE_DEPTH];
   bit [31:0]        id_pool[POOL_SIZE];
   logic [1:0]       all_ops[4] = '{OP_PUSH, OP_POP, OP_CLEAN, OP_UNUSED};

   keyed_event_queue_set DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_owner_id(req_owner_id),
      .req_event_kind(req_event_kind),
      .req_control_ident(req_control_ident),
      .req_window_ident(req_window_ident),
      .req_callback_word(req_callback_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_got_kind(rsp_got_kind),
      .rsp_got_control(rsp_got_control),
      .rsp_got_window(rsp_got_window),
      .rsp_got_callback(rsp_got_callback)
   );

   function automatic outcome_type queue_set_outcome(request_type r);
      outcome_type res;
      int s;
      int nxt;
      int base;
      res = '0;
      res.status = ST_DONE;
      if (r.op == OP_PUSH || r.op == OP_POP) begin
         s = -1;
         if (r.id != 0) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
               if (s < 0 && ring_owner[i] == r.id) begin
                  s = i;
               end
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
               if (s < 0 && ring_owner[i] == 0) begin
                  s = i;
                  ring_owner[i] = r.id;
                  ring_rd[i] = '0;
                  ring_wr[i] = '0;
               end
            end
         end
         if (s < 0) begin
            res.status = ST_NOQ;
         end else if (r.op == OP_PUSH) begin
            nxt = (int'(ring_wr[s]) + 1) % QUEUE_DEPTH;
            if (nxt == int'(ring_rd[s])) begin
               res.status = ST_FULL;
            end else begin
               base = s * QUEUE_DEPTH + int'(ring_wr[s]);
               stored_events[base] = r.ev;
               ring_wr[s] = PTR_W'(nxt);
            end
         end else begin
            if (ring_rd[s] == ring_wr[s]) begin
               res.status = ST_EMPTY;
            end else begin
               base = s * QUEUE_DEPTH + int'(ring_rd[s]);
               res.ev = stored_events[base];
               ring_rd[s] = PTR_W'((int'(ring_rd[s]) + 1) % QUEUE_DEPTH);
            end
         end
      end else if (r.op == OP_CLEAN) begin
         if (r.id == 0) begin
            res.status = ST_NOQ;
         end else begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
               if (ring_owner[i] == r.id) begin
                  ring_owner[i] = '0;
                  ring_rd[i] = '0;
                  ring_wr[i] = '0;
               end
            end
         end
      end else begin
         res.status = ST_NOQ;
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_outcomes.push_back(queue_set_outcome(request_on_bus));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               request_on_bus = pending_requests.pop_front();
               req_operation <= request_on_bus.op;
               req_owner_id <= request_on_bus.id;
               req_event_kind <= request_on_bus.ev.kind;
               req_control_ident <= request_on_bus.ev.control;
               req_window_ident <= request_on_bus.ev.window;
               req_callback_word <= request_on_bus.ev.callback;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected transfer on the response channel, status %0d", rsp_status);
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("got_kind", 64'(want.ev.kind), 64'(rsp_got_kind));
               check_field("got_control", 64'(want.ev.control), 64'(rsp_got_control));
               check_field("got_window", 64'(want.ev.window), 64'(rsp_got_window));
               check_field("got_callback", want.ev.callback, rsp_got_callback);
            end
         end
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic enqueue_with(logic [1:0] op, logic [31:0] id, keqs_event_type ev);
      request_type r;
      r.op = op;
      r.id = id;
      r.ev = ev;
      pending_requests.push_back(r);
   endtask

   task automatic enqueue(logic [1:0] op, logic [31:0] id);
      keqs_event_type ev;
      ev.kind = 8'($urandom);
      ev.control = $urandom;
      ev.window = $urandom;
      ev.callback = {$urandom, $urandom};
      enqueue_with(op, id, ev);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || awaited_outcomes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic generate_traffic(int count);
      int made;
      int pick;
      int len;
      int push_pct;
      logic [1:0] op;
      logic [31:0] id;
      logic [31:0] storm_ids[$];
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            id = id_pool[$urandom_range(POOL_SIZE - 1)];
            len = $urandom_range(1, 24);
            case ($urandom_range(2))
               0: begin
                  push_pct = 20;
               end
               1: begin
                  push_pct = 50;
               end
               default: begin
                  push_pct = 85;
               end
            endcase
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 3) begin
                  op = OP_CLEAN;
               end else if ($urandom_range(99) < push_pct) begin
                  op = OP_PUSH;
               end else begin
                  op = OP_POP;
               end
               enqueue(op, id);
            end
            made += len;
         end else if (pick < 78) begin
            len = $urandom_range(10, 72);
            storm_ids.delete();
            for (int i = 0; i < len; i++) begin
               id = $urandom;
               storm_ids.push_back(id);
               enqueue($urandom_range(1) ? OP_POP : OP_PUSH, id);
            end
            foreach (storm_ids[i]) begin
               enqueue(OP_CLEAN, storm_ids[i]);
            end
            made += 2 * len;
         end else if (pick < 90) begin
            case ($urandom_range(3))
               0: begin
                  enqueue(OP_UNUSED, $urandom);
               end
               1: begin
                  enqueue(all_ops[$urandom_range(3)], '0);
               end
               2: begin
                  enqueue(OP_CLEAN, $urandom);
               end
               default: begin
                  enqueue(OP_CLEAN, id_pool[$urandom_range(POOL_SIZE - 1)]);
               end
            endcase
            made++;
         end else begin
            id = id_pool[$urandom_range(POOL_SIZE - 1)];
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
               enqueue(OP_POP, id);
            end
            made += len;
         end
      end
   endtask

   initial begin
      keqs_event_type ones;
      keqs_event_type zeros;
      ones = '1;
      zeros = '0;
      foreach (id_pool[i]) begin
         id_pool[i] = $urandom;
         if (id_pool[i] == 0) begin
            id_pool[i] = 32'h1;
         end
      end
      id_pool[0] = 32'hFFFF_FFFE;
      id_pool[1] = 32'h1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: the id-zero cases, an unused opcode, cleanup of an unknown
      // id, a pop that claims a fresh slot, extreme payloads and a full ring.
      enqueue(OP_PUSH, '0);
      enqueue(OP_POP, '0);
      enqueue(OP_CLEAN, '0);
      enqueue(OP_UNUSED, 32'h5);
      enqueue(OP_CLEAN, 32'h7);
      enqueue(OP_POP, 32'hFFFF_FFFF);
      enqueue_with(OP_PUSH, 32'hFFFF_FFFF, ones);
      enqueue(OP_POP, 32'hFFFF_FFFF);
      enqueue(OP_POP, 32'hFFFF_FFFF);
      enqueue_with(OP_PUSH, 32'h8000_0000, zeros);
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         enqueue(OP_PUSH, 32'h8000_0000);
      end
      wait_drained();

      generate_traffic(450);
      wait_drained();

      send_idle_pct = 77;
      generate_traffic(350);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 77;
      generate_traffic(350);
      wait_drained();

      send_idle_pct = 31;
      recv_stall_pct = 31;
      generate_traffic(450);
      wait_drained();

      // Back-pressure: the response side holds off while requests keep coming.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      generate_traffic(250);
      hold_rsp = 1'b1;
      repeat (400) @(negedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
rtl/keqs_pkg.sv
rtl/keqs_ctrl.sv
rtl/keqs_dp.sv
rtl/keyed_event_queue_set.sv
rtl/keqs_checker.sv
tb/keyed_event_queue_set_tb.sv
